// ----- src/toa_plume_direction_estimator_unit_macros.svh -----
// Assertion macros used by the port-level checker of the plume direction estimator.
`ifndef TOA_PLUME_DIRECTION_ESTIMATOR_UNIT_MACROS_SVH
`define TOA_PLUME_DIRECTION_ESTIMATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPDE_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tpde assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPDE_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tpde assertion failed");

`endif

// ----- src/tpde_pkg.sv -----
// Package with widths, register codes, reset values and types of the estimator.
`timescale 1ns / 1ps
`default_nettype none
package tpde_pkg;

  localparam int TimeW    = 32;
  localparam int UaW      = TimeW + 1;
  localparam int UmW      = TimeW;
  localparam int A2W      = 2 * UaW;
  localparam int M2W      = 2 * UmW;
  localparam int M3W      = 2 * TimeW + 2;
  localparam int D2W      = 2 * TimeW + 3;
  localparam int D2LoW    = 34;
  localparam int D2HiW    = D2W - D2LoW;

  localparam int LenW     = 30;
  localparam int L2W      = 2 * LenW;
  localparam int SqW      = 32;
  localparam int ProdW    = SqW + D2W;

  // Quotient of a squared component over d2, scaled by 2^32, needs 33 bits.
  localparam int QW       = 33;
  localparam int DivStages = QW;
  localparam int RootW    = 17;
  localparam int SqrtStages = RootW;
  localparam int OpW      = 2 * RootW;
  localparam int RemW     = RootW + 3;
  localparam int KW       = 17;
  localparam int OutW     = 16;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int RadiusW  = 10;
  localparam int WindW    = 16;
  localparam int ScaleW   = 20;

  localparam logic [CfgIdxW-1:0] RegRadius  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWindMin = 2'd1;
  localparam logic [CfgIdxW-1:0] RegWindMax = 2'd2;

  localparam logic [ScaleW-1:0]  SpeedScale = 20'd768000;
  localparam logic [RadiusW-1:0] RadiusRst  = 10'd100;
  localparam logic [WindW-1:0]   WindMinRst = 16'd0;
  localparam logic [WindW-1:0]   WindMaxRst = 16'd2560;
  localparam logic [LenW-1:0]    LenRst     = 30'd76800000;
  localparam logic [L2W-1:0]     L2Rst      = 60'd5898240000000000;
  localparam logic [SqW-1:0]     WminSqRst  = 32'd0;
  localparam logic [SqW-1:0]     WmaxSqRst  = 32'd6553600;

  localparam logic [KW-1:0]      KMax       = 17'd32768;
  localparam logic [OutW-1:0]    OutMax     = 16'h7fff;

  typedef struct packed {
    logic zero;
    logic a_pos;
    logic m_pos;
    logic ok;
  } side_t;

  typedef struct packed {
    logic [D2W-1:0] d2;
    logic [M3W-1:0] m3;
    logic [A2W-1:0] a2;
    side_t          side;
  } sq_t;

  typedef struct packed {
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
    side_t         side;
  } quo_t;

  typedef struct packed {
    logic [RootW-1:0] sx;
    logic [RootW-1:0] sy;
    side_t            side;
  } root_t;

  typedef struct packed {
    logic [SqW-1:0] wmin_sq;
    logic [SqW-1:0] wmax_sq;
    logic [L2W-1:0] l2;
  } lim_t;

endpackage
`default_nettype wire

// ----- src/tpde_front.sv -----
// Front stages: delay sums and differences, their squares and the squared norm.
`timescale 1ns / 1ps
`default_nettype none
module tpde_front (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       en_i,
  input  wire                       valid_i,
  input  wire [tpde_pkg::TimeW-1:0] tc_i,
  input  wire [tpde_pkg::TimeW-1:0] tl_i,
  input  wire [tpde_pkg::TimeW-1:0] tr_i,
  output logic                      valid_o,
  output tpde_pkg::sq_t             data_o
);
  import tpde_pkg::*;

  logic signed [TimeW+2:0] a_w;
  logic signed [TimeW:0]   m_w;
  logic [TimeW+2:0]        a_abs;
  logic [TimeW:0]          m_abs;
  side_t                   side_d;

  logic         v1_q, v2_q, v3_q;
  logic [UaW-1:0] ua1_q;
  logic [UmW-1:0] um1_q;
  side_t        side1_q, side2_q, side3_q;
  logic [A2W-1:0] a2_d, a2_q, a2b_q;
  logic [M2W-1:0] m2_d, m2_q;
  logic [M3W-1:0] m3_d, m3_q;
  logic [D2W-1:0] d2_d, d2_q;

  // a = left + right - 2*center, m = left - right.
  assign a_w = $signed({3'b000, tl_i}) + $signed({3'b000, tr_i})
             - $signed({2'b00, tc_i, 1'b0});
  assign m_w = $signed({1'b0, tl_i}) - $signed({1'b0, tr_i});
  assign a_abs = a_w[TimeW+2] ? (~a_w + 1'b1) : a_w;
  assign m_abs = m_w[TimeW] ? (~m_w + 1'b1) : m_w;

  always_comb begin
    side_d.zero  = (a_w == '0) && (m_w == '0);
    side_d.a_pos = !a_w[TimeW+2] && (a_w != '0);
    side_d.m_pos = !m_w[TimeW] && (m_w != '0);
    side_d.ok    = 1'b0;
  end

  assign a2_d = ua1_q * ua1_q;
  assign m2_d = um1_q * um1_q;
  assign m3_d = {2'b00, m2_q} + {1'b0, m2_q, 1'b0};
  assign d2_d = {1'b0, m3_d} + {1'b0, a2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua1_q   <= a_abs[UaW-1:0];
      um1_q   <= m_abs[UmW-1:0];
      side1_q <= side_d;
      a2_q    <= a2_d;
      m2_q    <= m2_d;
      side2_q <= side1_q;
      m3_q    <= m3_d;
      d2_q    <= d2_d;
      a2b_q   <= a2_q;
      side3_q <= side2_q;
    end
  end

  assign valid_o     = v3_q;
  assign data_o.d2   = d2_q;
  assign data_o.m3   = m3_q;
  assign data_o.a2   = a2b_q;
  assign data_o.side = side3_q;

endmodule
`default_nettype wire

// ----- src/tpde_chk.sv -----
// Wind speed limit check done exactly on squares over three stages.
`timescale 1ns / 1ps
`default_nettype none
module tpde_chk (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            en_i,
  input  wire            valid_i,
  input  tpde_pkg::sq_t  data_i,
  input  tpde_pkg::lim_t lim_i,
  output logic           valid_o,
  output tpde_pkg::sq_t  data_o
);
  import tpde_pkg::*;

  localparam int LoPW = SqW + D2LoW;
  localparam int HiPW = SqW + D2HiW;

  logic v1_q, v2_q, v3_q;
  sq_t  d1_q, d2_q, d3_q;
  logic [LoPW-1:0] pmax_lo_q, pmin_lo_q;
  logic [HiPW-1:0] pmax_hi_q, pmin_hi_q;
  logic [LoPW-1:0] pmin_lo_d;
  logic [HiPW-1:0] pmin_hi_d;
  logic [LoPW-1:0] pmax_lo_d;
  logic [HiPW-1:0] pmax_hi_d;
  logic [ProdW-1:0] pmax_w, pmin_w, l2_w;
  logic over_d, over_q, under_w;
  sq_t  out_d;

  assign pmax_lo_d = lim_i.wmax_sq * data_i.d2[D2LoW-1:0];
  assign pmax_hi_d = lim_i.wmax_sq * data_i.d2[D2W-1:D2LoW];
  assign pmin_lo_d = lim_i.wmin_sq * d1_q.d2[D2LoW-1:0];
  assign pmin_hi_d = lim_i.wmin_sq * d1_q.d2[D2W-1:D2LoW];

  assign l2_w   = {{(ProdW-L2W){1'b0}}, lim_i.l2};
  assign pmax_w = {pmax_hi_q, {D2LoW{1'b0}}} + {{(ProdW-LoPW){1'b0}}, pmax_lo_q};
  assign pmin_w = {pmin_hi_q, {D2LoW{1'b0}}} + {{(ProdW-LoPW){1'b0}}, pmin_lo_q};
  assign over_d  = l2_w > pmax_w;
  assign under_w = l2_w < pmin_w;

  always_comb begin
    out_d = d2_q;
    out_d.side.ok = !d2_q.side.zero && !over_q && !under_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q      <= data_i;
      pmax_lo_q <= pmax_lo_d;
      pmax_hi_q <= pmax_hi_d;
      d2_q      <= d1_q;
      over_q    <= over_d;
      pmin_lo_q <= pmin_lo_d;
      pmin_hi_q <= pmin_hi_d;
      d3_q      <= out_d;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = d3_q;

endmodule
`default_nettype wire

// ----- src/tpde_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, two lanes over d2.
`timescale 1ns / 1ps
`default_nettype none
module tpde_div (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            en_i,
  input  wire            valid_i,
  input  tpde_pkg::sq_t  data_i,
  output logic           valid_o,
  output tpde_pkg::quo_t data_o
);
  import tpde_pkg::*;

  logic             v_q  [DivStages];
  logic [D2W-1:0]   rx_q [DivStages];
  logic [D2W-1:0]   ry_q [DivStages];
  logic [D2W-1:0]   dd_q [DivStages];
  logic [QW-1:0]    qx_q [DivStages];
  logic [QW-1:0]    qy_q [DivStages];
  side_t            sd_q [DivStages];

  logic [D2W-1:0]   rx_d [DivStages];
  logic [D2W-1:0]   ry_d [DivStages];
  logic [QW-1:0]    qx_d [DivStages];
  logic [QW-1:0]    qy_d [DivStages];
  logic [D2W-1:0]   nx_w, ny_w;

  // The numerator never exceeds d2, so the first stage is a single compare.
  function automatic logic [D2W:0] first_step(input logic [D2W-1:0] num,
                                              input logic [D2W-1:0] den);
    logic [D2W-1:0] diff;
    diff = num - den;
    if (num >= den) begin
      return {1'b1, diff};
    end else begin
      return {1'b0, num};
    end
  endfunction

  function automatic logic [D2W:0] next_step(input logic [D2W-1:0] rem,
                                             input logic [D2W-1:0] den);
    logic [D2W:0] trial;
    logic [D2W:0] diff;
    trial = {rem, 1'b0};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      return {1'b1, diff[D2W-1:0]};
    end else begin
      return {1'b0, trial[D2W-1:0]};
    end
  endfunction

  assign nx_w = {{(D2W-M3W){1'b0}}, data_i.m3};
  assign ny_w = {{(D2W-A2W){1'b0}}, data_i.a2};

  always_comb begin
    logic [D2W:0] sx;
    logic [D2W:0] sy;
    sx = first_step(nx_w, data_i.d2);
    sy = first_step(ny_w, data_i.d2);
    rx_d[0] = sx[D2W-1:0];
    ry_d[0] = sy[D2W-1:0];
    qx_d[0] = {{(QW-1){1'b0}}, sx[D2W]};
    qy_d[0] = {{(QW-1){1'b0}}, sy[D2W]};
    for (int s = 1; s < DivStages; s++) begin
      sx = next_step(rx_q[s-1], dd_q[s-1]);
      sy = next_step(ry_q[s-1], dd_q[s-1]);
      rx_d[s] = sx[D2W-1:0];
      ry_d[s] = sy[D2W-1:0];
      qx_d[s] = {qx_q[s-1][QW-2:0], sx[D2W]};
      qy_d[s] = {qy_q[s-1][QW-2:0], sy[D2W]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DivStages; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s < DivStages; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dd_q[0] <= data_i.d2;
      sd_q[0] <= data_i.side;
      for (int s = 1; s < DivStages; s++) begin
        dd_q[s] <= dd_q[s-1];
        sd_q[s] <= sd_q[s-1];
      end
      for (int s = 0; s < DivStages; s++) begin
        rx_q[s] <= rx_d[s];
        ry_q[s] <= ry_d[s];
        qx_q[s] <= qx_d[s];
        qy_q[s] <= qy_d[s];
      end
    end
  end

  assign valid_o     = v_q[DivStages-1];
  assign data_o.qx   = qx_q[DivStages-1];
  assign data_o.qy   = qy_q[DivStages-1];
  assign data_o.side = sd_q[DivStages-1];

endmodule
`default_nettype wire

// ----- src/tpde_sqrt.sv -----
// Pipelined digit-by-digit integer square root, one root bit per stage, two lanes.
`timescale 1ns / 1ps
`default_nettype none
module tpde_sqrt (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             en_i,
  input  wire             valid_i,
  input  tpde_pkg::quo_t  data_i,
  output logic            valid_o,
  output tpde_pkg::root_t data_o
);
  import tpde_pkg::*;

  logic              v_q   [SqrtStages];
  logic [OpW-1:0]    opx_q [SqrtStages];
  logic [OpW-1:0]    opy_q [SqrtStages];
  logic [RemW-1:0]   rmx_q [SqrtStages];
  logic [RemW-1:0]   rmy_q [SqrtStages];
  logic [RootW-1:0]  rtx_q [SqrtStages];
  logic [RootW-1:0]  rty_q [SqrtStages];
  side_t             sd_q  [SqrtStages];

  logic [OpW-1:0]    opx_d [SqrtStages];
  logic [OpW-1:0]    opy_d [SqrtStages];
  logic [RemW-1:0]   rmx_d [SqrtStages];
  logic [RemW-1:0]   rmy_d [SqrtStages];
  logic [RootW-1:0]  rtx_d [SqrtStages];
  logic [RootW-1:0]  rty_d [SqrtStages];

  // Brings down the next two operand bits and tries the next root bit.
  function automatic logic [RemW+RootW-1:0] root_step(input logic [RemW-1:0]  rem,
                                                      input logic [RootW-1:0] root,
                                                      input logic [1:0]       pair);
    logic [RemW-1:0] remt;
    logic [RemW-1:0] trial;
    remt  = {rem[RemW-3:0], pair};
    trial = {1'b0, root, 2'b01};
    if (remt >= trial) begin
      return {remt - trial, root[RootW-2:0], 1'b1};
    end else begin
      return {remt, root[RootW-2:0], 1'b0};
    end
  endfunction

  always_comb begin
    logic [RemW+RootW-1:0] sx;
    logic [RemW+RootW-1:0] sy;
    logic [OpW-1:0]        ox;
    logic [OpW-1:0]        oy;
    ox = {{(OpW-QW){1'b0}}, data_i.qx};
    oy = {{(OpW-QW){1'b0}}, data_i.qy};
    sx = root_step('0, '0, ox[OpW-1:OpW-2]);
    sy = root_step('0, '0, oy[OpW-1:OpW-2]);
    opx_d[0] = {ox[OpW-3:0], 2'b00};
    opy_d[0] = {oy[OpW-3:0], 2'b00};
    rmx_d[0] = sx[RemW+RootW-1:RootW];
    rmy_d[0] = sy[RemW+RootW-1:RootW];
    rtx_d[0] = sx[RootW-1:0];
    rty_d[0] = sy[RootW-1:0];
    for (int s = 1; s < SqrtStages; s++) begin
      sx = root_step(rmx_q[s-1], rtx_q[s-1], opx_q[s-1][OpW-1:OpW-2]);
      sy = root_step(rmy_q[s-1], rty_q[s-1], opy_q[s-1][OpW-1:OpW-2]);
      opx_d[s] = {opx_q[s-1][OpW-3:0], 2'b00};
      opy_d[s] = {opy_q[s-1][OpW-3:0], 2'b00};
      rmx_d[s] = sx[RemW+RootW-1:RootW];
      rmy_d[s] = sy[RemW+RootW-1:RootW];
      rtx_d[s] = sx[RootW-1:0];
      rty_d[s] = sy[RootW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SqrtStages; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s < SqrtStages; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd_q[0] <= data_i.side;
      for (int s = 1; s < SqrtStages; s++) begin
        sd_q[s] <= sd_q[s-1];
      end
      for (int s = 0; s < SqrtStages; s++) begin
        opx_q[s] <= opx_d[s];
        opy_q[s] <= opy_d[s];
        rmx_q[s] <= rmx_d[s];
        rmy_q[s] <= rmy_d[s];
        rtx_q[s] <= rtx_d[s];
        rty_q[s] <= rty_d[s];
      end
    end
  end

  assign valid_o     = v_q[SqrtStages-1];
  assign data_o.sx   = rtx_q[SqrtStages-1];
  assign data_o.sy   = rty_q[SqrtStages-1];
  assign data_o.side = sd_q[SqrtStages-1];

endmodule
`default_nettype wire

// ----- src/toa_plume_direction_estimator_unit.sv -----
// Top level of the time-of-arrival plume direction estimator.
//
// Requests carry three arrival times (center, left, right) on a valid/stall
// channel; each request yields exactly one result of dir_ok, dir_x and dir_y
// (Q1.15) on the output valid/stall channel, in request order.
// From acceptance to the result, a request passes three front
// stages (delays, squares, squared norm), three speed-limit stages, a
// 33-stage divider that gives one quotient bit per stage and a 17-stage
// square root that gives one root bit per stage, then the output register.
// Throughput is one request per cycle while the output is not stalled.
// An output stall while a result waits freezes the whole pipeline, and
// in_stall_o is raised in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits and loads the register reset values: radius
// 100 mm, minimum speed 0, maximum speed 2560 (Q8.8 m/s). Configuration
// writes reach the limits through registers; the user must make them only
// while the pipeline holds no request, which the block does not enforce.
`timescale 1ns / 1ps
`default_nettype none
module toa_plume_direction_estimator_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [tpde_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [tpde_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire [tpde_pkg::TimeW-1:0]    time_center_i,
  input  wire [tpde_pkg::TimeW-1:0]    time_left_i,
  input  wire [tpde_pkg::TimeW-1:0]    time_right_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         dir_ok_o,
  output logic signed [tpde_pkg::OutW-1:0] dir_x_o,
  output logic signed [tpde_pkg::OutW-1:0] dir_y_o
);
  import tpde_pkg::*;

  logic [RadiusW-1:0] radius_q;
  logic [WindW-1:0]   wmin_q, wmax_q;
  logic [LenW-1:0]    len_q;
  logic [L2W-1:0]     l2_q;
  logic [SqW-1:0]     wmin_sq_q, wmax_sq_q;
  lim_t               lim;

  logic  en;
  logic  fr_v, ck_v, dv_v, sq_v;
  sq_t   fr_d, ck_d;
  quo_t  dv_d;
  root_t sq_d;

  logic               out_valid_q, ok_q;
  logic [OutW-1:0]    x_q, y_q;
  logic [OutW-1:0]    x_d, y_d;
  logic [KW-1:0]      kx, ky;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= RadiusRst;
      wmin_q    <= WindMinRst;
      wmax_q    <= WindMaxRst;
      len_q     <= LenRst;
      l2_q      <= L2Rst;
      wmin_sq_q <= WminSqRst;
      wmax_sq_q <= WmaxSqRst;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegRadius:  radius_q <= cfg_wdata_i[RadiusW-1:0];
          RegWindMin: wmin_q   <= cfg_wdata_i[WindW-1:0];
          RegWindMax: wmax_q   <= cfg_wdata_i[WindW-1:0];
          default: ;
        endcase
      end
      len_q     <= radius_q * SpeedScale;
      l2_q      <= len_q * len_q;
      wmin_sq_q <= wmin_q * wmin_q;
      wmax_sq_q <= wmax_q * wmax_q;
    end
  end

  assign lim = '{wmin_sq: wmin_sq_q, wmax_sq: wmax_sq_q, l2: l2_q};

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  tpde_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .tc_i    (time_center_i),
    .tl_i    (time_left_i),
    .tr_i    (time_right_i),
    .valid_o (fr_v),
    .data_o  (fr_d)
  );

  tpde_chk u_chk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .data_i  (fr_d),
    .lim_i   (lim),
    .valid_o (ck_v),
    .data_o  (ck_d)
  );

  tpde_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ck_v),
    .data_i  (ck_d),
    .valid_o (dv_v),
    .data_o  (dv_d)
  );

  tpde_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_v),
    .data_i  (dv_d),
    .valid_o (sq_v),
    .data_o  (sq_d)
  );

  // The rounded magnitude is half of one more than the largest odd number not above the root.
  function automatic logic [KW-1:0] round_k(input logic [RootW-1:0] s);
    logic [KW-1:0] sum;
    sum = {1'b0, s[RootW-2:0]} + {{(KW-1){1'b0}}, 1'b1};
    if (s[RootW-1]) begin
      return KMax;
    end else begin
      return {1'b0, sum[KW-1:1]};
    end
  endfunction

  function automatic logic [OutW-1:0] signed_comp(input logic [KW-1:0] k,
                                                  input logic          neg);
    logic [KW-1:0] nk;
    nk = ~k + {{(KW-1){1'b0}}, 1'b1};
    if (neg) begin
      return nk[OutW-1:0];
    end else if (k[KW-2]) begin
      return OutMax;
    end else begin
      return k[OutW-1:0];
    end
  endfunction

  assign kx  = round_k(sq_d.sx);
  assign ky  = round_k(sq_d.sy);
  assign x_d = sq_d.side.ok ? signed_comp(kx, sq_d.side.m_pos) : '0;
  assign y_d = sq_d.side.ok ? signed_comp(ky, sq_d.side.a_pos) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok_q <= sq_d.side.ok;
      x_q  <= x_d;
      y_q  <= y_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dir_ok_o    = ok_q;
  assign dir_x_o     = x_q;
  assign dir_y_o     = y_q;

endmodule
`default_nettype wire

// ----- src/tpde_checker.sv -----
// Port-level checker for the plume direction estimator and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "toa_plume_direction_estimator_unit_macros.svh"
module tpde_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          in_stall_o,
  input wire                          out_valid_o,
  input wire                          out_stall_i,
  input wire                          dir_ok_o,
  input wire [tpde_pkg::OutW-1:0]     dir_x_o,
  input wire [tpde_pkg::OutW-1:0]     dir_y_o
);
  import tpde_pkg::*;

  // A rejected result carries a zero vector.
  `TPDE_ASSERT_IMP(a_reject_zero, clk_i, rst_ni, out_valid_o && !dir_ok_o, dir_x_o == '0 && dir_y_o == '0)

  // An accepted unit vector can never be zero in both components.
  `TPDE_ASSERT_IMP(a_ok_nonzero, clk_i, rst_ni, out_valid_o && dir_ok_o, dir_x_o != '0 || dir_y_o != '0)

  // The input is held back only while a result waits on a stalled output.
  `TPDE_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // A stalled result stays in place.
  `TPDE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(dir_ok_o) && $stable(dir_x_o) && $stable(dir_y_o))

endmodule

bind toa_plume_direction_estimator_unit tpde_checker u_tpde_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .dir_ok_o    (dir_ok_o),
  .dir_x_o     (dir_x_o),
  .dir_y_o     (dir_y_o)
);
`default_nettype wire

// ----- tb/tpde_direction_checker.sv -----
// Checker that predicts and compares every plume direction result of the estimator.
`timescale 1ns / 1ps
module tpde_direction_checker (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [tpde_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [tpde_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire                          in_valid_i,
  input  wire                          in_stall_i,
  input  wire [tpde_pkg::TimeW-1:0]    time_center_i,
  input  wire [tpde_pkg::TimeW-1:0]    time_left_i,
  input  wire [tpde_pkg::TimeW-1:0]    time_right_i,
  input  wire                          out_valid_i,
  input  wire                          out_stall_i,
  input  wire                          dir_ok_i,
  input  wire [tpde_pkg::OutW-1:0]     dir_x_i,
  input  wire [tpde_pkg::OutW-1:0]     dir_y_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import tpde_pkg::*;

  typedef struct {
    logic            ok;
    logic [OutW-1:0] x;
    logic [OutW-1:0] y;
  } heading_t;

  heading_t        heading_q[$];
  logic [RadiusW-1:0] radius_mm;
  logic [WindW-1:0]   wind_min;
  logic [WindW-1:0]   wind_max;

  // Largest k in [0, 32768] with k == 0 or (2k-1)^2 * den <= num.
  function automatic int unsigned q15_round(logic [127:0] num, logic [127:0] den);
    int unsigned lo, hi, mid;
    logic [127:0] odd;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 2 * mid - 1;
      if (odd * odd * den <= num) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic heading_t plume_direction(logic [TimeW-1:0] tc, logic [TimeW-1:0] tl,
                                               logic [TimeW-1:0] tr);
    logic signed [34:0] dl, dr, a, m;
    logic [34:0] abs_a, abs_m;
    logic [127:0] a2, m2, d2, l2, wmax2, wmin2;
    int x, y;
    heading_t h;
    h.ok = 1'b0;
    h.x = '0;
    h.y = '0;
    dl = $signed({3'b0, tl}) - $signed({3'b0, tc});
    dr = $signed({3'b0, tr}) - $signed({3'b0, tc});
    if (dl == 0 && dr == 0) return h;
    a = dl + dr;
    m = dl - dr;
    abs_a = a[34] ? -a : a;
    abs_m = m[34] ? -m : m;
    a2 = 128'(abs_a) * 128'(abs_a);
    m2 = 128'(abs_m) * 128'(abs_m);
    d2 = 3 * m2 + a2;
    l2 = (128'(768000) * radius_mm) * (128'(768000) * radius_mm);
    wmax2 = 128'(wind_max) * wind_max;
    wmin2 = 128'(wind_min) * wind_min;
    if (l2 > wmax2 * d2 || l2 < wmin2 * d2) return h;
    x = int'(q15_round((128'(3) << 32) * m2, d2));
    y = int'(q15_round((128'(1) << 32) * a2, d2));
    if (m > 0) x = -x;
    if (a > 0) y = -y;
    if (x > 32767) x = 32767;
    if (y > 32767) y = 32767;
    h.ok = 1'b1;
    h.x = x[OutW-1:0];
    h.y = y[OutW-1:0];
    return h;
  endfunction

  assign pending_o = heading_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    heading_t want;
    if (!rst_ni) begin
      radius_mm <= RadiusRst;
      wind_min <= WindMinRst;
      wind_max <= WindMaxRst;
      heading_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegRadius:  radius_mm <= cfg_wdata_i[RadiusW-1:0];
          RegWindMin: wind_min <= cfg_wdata_i;
          RegWindMax: wind_max <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        heading_q.insert(heading_q.size(),
                         plume_direction(time_center_i, time_left_i, time_right_i));
      if (out_valid_i && !out_stall_i) begin
        if (heading_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = heading_q.pop_front();
          if (dir_ok_i !== want.ok || dir_x_i !== want.x || dir_y_i !== want.y) begin
            if (dir_ok_i !== want.ok)
              $error("dir_ok: expected %0d, got %0d", want.ok, dir_ok_i);
            if (dir_x_i !== want.x)
              $error("dir_x: expected %0d, got %0d", $signed(want.x), $signed(dir_x_i));
            if (dir_y_i !== want.y)
              $error("dir_y: expected %0d, got %0d", $signed(want.y), $signed(dir_y_i));
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/toa_plume_direction_estimator_unit_tb.sv -----
// Top of the testbench: clock, reset, requests, register settings and verdict.
`timescale 1ns / 1ps
module toa_plume_direction_estimator_unit_tb;
  import tpde_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam int PipeDrain = 70;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic [TimeW-1:0] time_center_i = '0;
  logic [TimeW-1:0] time_left_i = '0;
  logic [TimeW-1:0] time_right_i = '0;
  logic in_stall_o, out_valid_o, dir_ok_o;
  logic signed [OutW-1:0] dir_x_o, dir_y_o;
  int fail_count, pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  toa_plume_direction_estimator_unit DUT (.*);

  tpde_direction_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o),
    .time_center_i, .time_left_i, .time_right_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .dir_ok_i(dir_ok_o), .dir_x_i(dir_x_o), .dir_y_i(dir_y_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_times(logic [TimeW-1:0] tc, logic [TimeW-1:0] tl,
                            logic [TimeW-1:0] tr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    time_center_i <= tc;
    time_left_i <= tl;
    time_right_i <= tr;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (PipeDrain) @(negedge clk_i);
  endtask

  // Delay whose magnitude spans every scale from one bit wide to the full 32 bits.
  function automatic logic [TimeW-1:0] arrival_delay();
    logic [TimeW-1:0] v;
    int s;
    s = $urandom_range(32, 1);
    v = $urandom;
    if (s < 32) v = v & ((32'd1 << s) - 1);
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  task automatic send_random(int count);
    logic [TimeW-1:0] tc, dl, dr;
    int kind;
    repeat (count) begin
      kind = $urandom_range(99);
      tc = $urandom;
      dl = arrival_delay();
      dr = arrival_delay();
      if (kind < 12) dr = dl;
      else if (kind < 16) begin
        dl = '0;
        dr = '0;
      end else if (kind < 22) dl = '0;
      else if (kind < 28) dr = '0;
      if (kind >= 88) send_times($urandom, $urandom, $urandom);
      else send_times(tc, tc + dl, tc + dr);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = 18;
    recv_idle_pct = 52;

    // Directed requests under the reset settings.
    send_times(32'd0, 32'd0, 32'd0);
    send_times(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_times(32'd1000, 32'd41000, 32'd41000);
    send_times(32'd41000, 32'd1000, 32'd1000);
    send_times(32'd0, 32'd30000, 32'd0);
    send_times(32'd0, 32'd0, 32'd30000);
    send_times(32'd50000, 32'd20000, 32'd80000);
    send_times(32'd50000, 32'd80000, 32'd20000);
    send_times(32'd0, 32'hffff_ffff, 32'hffff_ffff);
    send_times(32'hffff_ffff, 32'd0, 32'd0);
    send_times(32'd0, 32'hffff_ffff, 32'd0);
    send_times(32'hffff_ffff, 32'd0, 32'hffff_ffff);
    send_times(32'hffff_fff0, 32'd9000, 32'd60000);
    send_times(32'd100, 32'd101, 32'd100);
    send_times(32'd0, 32'd34641, 32'd34641);
    send_times(32'd0, 32'd30000, 32'd0);
    send_times(32'd5, 32'd17325, 32'd17325);
    send_times(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678);
    wait_idle();

    // Widest radius and a wide speed window.
    write_reg(RegRadius, 16'd1023);
    write_reg(RegWindMax, 16'hffff);
    write_reg(RegUnused, 16'hffff);
    repeat (4) @(negedge clk_i);
    send_random(320);
    wait_idle();

    send_idle_pct = 52;
    recv_idle_pct = 18;
    write_reg(RegRadius, 16'd1);
    write_reg(RegWindMin, 16'd1);
    write_reg(RegWindMax, 16'd4000);
    repeat (4) @(negedge clk_i);
    send_random(320);
    wait_idle();

    // A radius write above ten bits folds to zero; only a zero minimum passes it.
    write_reg(RegRadius, 16'h0400);
    write_reg(RegWindMin, 16'd0);
    repeat (4) @(negedge clk_i);
    send_random(200);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(RegRadius, 16'd100);
    write_reg(RegWindMin, 16'd3000);
    write_reg(RegWindMax, 16'd2000);
    repeat (4) @(negedge clk_i);
    send_random(200);
    wait_idle();

    write_reg(RegRadius, 16'd500);
    write_reg(RegWindMin, 16'd256);
    write_reg(RegWindMax, 16'd25600);
    repeat (4) @(negedge clk_i);
    send_random(500);
    send_random(460);
    wait_idle();

    if (fail_count == 0) begin
      $display("** toa_plume_direction_estimator_unit: PASSED **");
    end else begin
      $display("** toa_plume_direction_estimator_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("** toa_plume_direction_estimator_unit: FAILED **");
    $finish;
  end

endmodule

// ----- toa_plume_direction_estimator_unit.f -----
+incdir+src
src/tpde_pkg.sv
src/tpde_front.sv
src/tpde_chk.sv
src/tpde_div.sv
src/tpde_sqrt.sv
src/toa_plume_direction_estimator_unit.sv
src/tpde_checker.sv
tb/tpde_direction_checker.sv
tb/toa_plume_direction_estimator_unit_tb.sv
